[hdl/bicd_pkg.sv]
// shared types, constants and group decoding for the bus instance conflict detector
package bicd_pkg;

   localparam int GRP_W  = 17;
   localparam int SRC_W  = 8;
   localparam int INST_W = 8;
   localparam int LEN_W  = 8;
   localparam int CNT_W  = 6;
   localparam int NUM_SOURCES = 256;

   localparam logic [INST_W-1:0] NO_INSTANCE = 8'd255;
   localparam logic [CNT_W-1:0]  COUNT_MAX   = 6'd63;

   localparam logic [GRP_W-1:0] PGN_SWITCH_STATUS   = 17'd127488;
   localparam logic [GRP_W-1:0] PGN_ENGINE_DYNAMIC  = 17'd127489;
   localparam logic [GRP_W-1:0] PGN_SWITCH_CONTROL  = 17'd127502;
   localparam logic [GRP_W-1:0] PGN_FLUID_LEVEL     = 17'd127505;
   localparam logic [GRP_W-1:0] PGN_BATTERY_STATUS  = 17'd127508;
   localparam logic [GRP_W-1:0] PGN_INVERTER_STATUS = 17'd127509;
   localparam logic [GRP_W-1:0] PGN_BATTERY_CONFIG  = 17'd127513;
   localparam logic [GRP_W-1:0] PGN_TEMPERATURE     = 17'd130312;
   localparam logic [GRP_W-1:0] PGN_PRESSURE        = 17'd130314;
   localparam logic [GRP_W-1:0] PGN_TEMPERATURE_EXT = 17'd130316;

   localparam logic [LEN_W-1:0] LEN_BYTE0 = 8'd1;
   localparam logic [LEN_W-1:0] LEN_BYTE1 = 8'd2;

   typedef enum logic [1:0] {
      GK_NONE,
      GK_BYTE0,
      GK_BYTE1
   } gkind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MARK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [GRP_W-1:0]  grp;
      logic [SRC_W-1:0]  src;
      logic [INST_W-1:0] inst;
   } entry_type;

   typedef struct packed {
      logic              found;
      logic              inst_one;
      logic              inst_many;
      logic [SRC_W-1:0]  other;
   } scan_type;

   function automatic gkind_type group_kind(input logic [GRP_W-1:0] g);
      gkind_type k;
      case (g) inside
         PGN_SWITCH_STATUS, PGN_ENGINE_DYNAMIC, PGN_FLUID_LEVEL,
         PGN_BATTERY_STATUS, PGN_INVERTER_STATUS, PGN_BATTERY_CONFIG: k = GK_BYTE0;
         PGN_SWITCH_CONTROL, PGN_TEMPERATURE, PGN_PRESSURE,
         PGN_TEMPERATURE_EXT: k = GK_BYTE1;
         default: k = GK_NONE;
      endcase
      return k;
   endfunction

endpackage

[hdl/bicd_mem.sv]
// entry table memory, one write port and one registered read port
module bicd_mem
   import bicd_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data_ff
);

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[hdl/bicd_match.sv]
// shared entry compare unit with scan accumulators
module bicd_match
   import bicd_pkg::*;
(
   input  logic              clock,
   input  logic              start,
   input  logic              cmp_valid,
   input  entry_type         entry,
   input  logic [GRP_W-1:0]  key_grp,
   input  logic [SRC_W-1:0]  key_src,
   input  logic [INST_W-1:0] key_inst,
   output scan_type          scan_ff
);

   logic     grp_hit;
   logic     pair_hit;
   logic     inst_hit;
   scan_type scan_in;

   assign grp_hit  = (entry.grp == key_grp);
   assign pair_hit = grp_hit && (entry.src == key_src);
   assign inst_hit = grp_hit && (entry.inst == key_inst);

   always_comb begin
      scan_in = scan_ff;
      if (start) begin
         scan_in = '0;
      end else if (cmp_valid) begin
         if (pair_hit) begin
            scan_in.found = 1'b1;
         end
         if (inst_hit) begin
            scan_in.inst_many = scan_ff.inst_one;
            scan_in.inst_one  = 1'b1;
            scan_in.other     = entry.src;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

endmodule

[hdl/bus_instance_conflict_detector_top.sv]
// top level: request decode, scan sequencer, conflict bookkeeping and response register
//
// one request in, one response out, both on stream channels
// req_tuser = kind (0 track a message, 1 clear all history), req_tdata = message fields
// each tracked request scans the stored (group, source) entries one per cycle through a
// single compare unit fed by the table memory's registered read port
// a clear or an untracked message goes from S_IDLE through S_MARK to S_RESP; a tracked
// message scans the table in S_SCAN (skipped with an empty table), then passes through
// S_DECIDE and S_MARK to S_RESP
// throughput: one request at a time, req_tready is high only while idle
// the response is held in a register until rsp_tready; no new request is taken meanwhile
// reset empties the table, the conflict count and every per-source flag at once;
// the table contents themselves are not cleared, the fill count guards them
// a full table drops new pairs and reports table_full
module bus_instance_conflict_detector_top
   import bicd_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // pgn[16:0] source[24:17] data_len[32:25] byte0[40:33] byte1[48:41]
   input  logic [0:0]  req_tuser,  // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // tracked[0] instance_seen[8:1] new_entry[9] table_full[10]
                                   // conflict_count[16:11] source_conflicted[17]
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [GRP_W-1:0]       req_pgn;
   logic [SRC_W-1:0]       req_source;
   logic [LEN_W-1:0]       req_len;
   logic [INST_W-1:0]      req_byte0;
   logic [INST_W-1:0]      req_byte1;
   logic                   req_clear;
   logic [INST_W-1:0]      inst_pick;
   gkind_type              gkind;
   logic                   accept;

   logic [GRP_W-1:0]       key_grp_ff, key_grp_in;
   logic [SRC_W-1:0]       key_src_ff, key_src_in;
   logic [INST_W-1:0]      key_inst_ff, key_inst_in;
   logic                   rsp_tracked_ff, rsp_tracked_in;
   logic                   rsp_new_ff, rsp_new_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic                   rsp_srcconf_ff, rsp_srcconf_in;
   logic                   mark_src_ff, mark_src_in;
   logic [CW-1:0]          issue_cnt_ff, issue_cnt_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [CW-1:0]          entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]       conflict_total_ff, conflict_total_in;
   logic [NUM_SOURCES-1:0] flag_ff, flag_in;

   logic                   scan_issue;
   logic                   in_decide;
   logic                   in_mark;
   logic                   tbl_we;
   entry_type              tbl_wdata;
   entry_type              tbl_rdata;
   scan_type               scan;

   assign req_pgn    = req_tdata[16:0];
   assign req_source = req_tdata[24:17];
   assign req_len    = req_tdata[32:25];
   assign req_byte0  = req_tdata[40:33];
   assign req_byte1  = req_tdata[48:41];
   assign req_clear  = req_tuser[0];
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      gkind     = group_kind(req_pgn);
      inst_pick = NO_INSTANCE;
      if (!req_clear) begin
         if (gkind == GK_BYTE0 && req_len >= LEN_BYTE0) begin
            inst_pick = req_byte0;
         end else if (gkind == GK_BYTE1 && req_len >= LEN_BYTE1) begin
            inst_pick = req_byte1;
         end
      end
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_clear || inst_pick == NO_INSTANCE) begin
                  state_in = S_MARK;
               end else if (entry_count_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue_cnt_ff == entry_count_ff && !cmp_valid_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: state_in = S_MARK;
         S_MARK:   state_in = S_RESP;
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_RESP);
      scan_issue = (state_ff == S_SCAN) && (issue_cnt_ff != entry_count_ff);
      in_decide  = (state_ff == S_DECIDE);
      in_mark    = (state_ff == S_MARK);
   end

   // datapath next values
   always_comb begin
      key_grp_in        = key_grp_ff;
      key_src_in        = key_src_ff;
      key_inst_in       = key_inst_ff;
      rsp_tracked_in    = rsp_tracked_ff;
      rsp_new_in        = rsp_new_ff;
      rsp_full_in       = rsp_full_ff;
      rsp_srcconf_in    = rsp_srcconf_ff;
      mark_src_in       = mark_src_ff;
      issue_cnt_in      = issue_cnt_ff;
      cmp_valid_in      = scan_issue;
      entry_count_in    = entry_count_ff;
      conflict_total_in = conflict_total_ff;
      flag_in           = flag_ff;
      tbl_we            = 1'b0;

      if (accept) begin
         key_grp_in     = req_pgn;
         key_src_in     = req_source;
         key_inst_in    = inst_pick;
         rsp_tracked_in = (inst_pick != NO_INSTANCE);
         rsp_new_in     = 1'b0;
         rsp_full_in    = 1'b0;
         mark_src_in    = 1'b0;
         issue_cnt_in   = '0;
         if (req_clear) begin
            entry_count_in    = '0;
            conflict_total_in = '0;
            flag_in           = '0;
         end
      end

      if (scan_issue) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end

      if (in_decide && !scan.found) begin
         if (entry_count_ff >= DEPTH_C) begin
            rsp_full_in = 1'b1;
         end else begin
            tbl_we         = 1'b1;
            entry_count_in = entry_count_ff + 1'b1;
            rsp_new_in     = 1'b1;
            if (scan.inst_one && !scan.inst_many) begin
               if (conflict_total_ff < COUNT_MAX) begin
                  conflict_total_in = conflict_total_ff + 1'b1;
               end
               flag_in[scan.other] = 1'b1;
            end
            if (scan.inst_one) begin
               mark_src_in = 1'b1;
            end
         end
      end

      if (in_mark) begin
         if (mark_src_ff) begin
            flag_in[key_src_ff] = 1'b1;
         end
         rsp_srcconf_in = flag_ff[key_src_ff] || mark_src_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         entry_count_ff    <= '0;
         conflict_total_ff <= '0;
         flag_ff           <= '0;
         cmp_valid_ff      <= 1'b0;
         issue_cnt_ff      <= '0;
         mark_src_ff       <= 1'b0;
      end else begin
         state_ff          <= state_in;
         entry_count_ff    <= entry_count_in;
         conflict_total_ff <= conflict_total_in;
         flag_ff           <= flag_in;
         cmp_valid_ff      <= cmp_valid_in;
         issue_cnt_ff      <= issue_cnt_in;
         mark_src_ff       <= mark_src_in;
      end
   end

   always_ff @(posedge clock) begin
      key_grp_ff     <= key_grp_in;
      key_src_ff     <= key_src_in;
      key_inst_ff    <= key_inst_in;
      rsp_tracked_ff <= rsp_tracked_in;
      rsp_new_ff     <= rsp_new_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_srcconf_ff <= rsp_srcconf_in;
   end

   assign tbl_wdata.grp  = key_grp_ff;
   assign tbl_wdata.src  = key_src_ff;
   assign tbl_wdata.inst = key_inst_ff;

   bicd_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (entry_count_ff[AW-1:0]),
      .wr_data    (tbl_wdata),
      .rd_en      (scan_issue),
      .rd_addr    (issue_cnt_ff[AW-1:0]),
      .rd_data_ff (tbl_rdata)
   );

   bicd_match u_match (
      .clock     (clock),
      .start     (accept),
      .cmp_valid (cmp_valid_ff),
      .entry     (tbl_rdata),
      .key_grp   (key_grp_ff),
      .key_src   (key_src_ff),
      .key_inst  (key_inst_ff),
      .scan_ff   (scan)
   );

   assign rsp_tdata = {6'd0, rsp_srcconf_ff, conflict_total_ff, rsp_full_ff, rsp_new_ff,
                       key_inst_ff, rsp_tracked_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while response pending");

   a_new_or_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_new_ff && rsp_full_ff))
      else $error("entry both stored and dropped");

   a_new_tracked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_new_ff || rsp_full_ff)) |-> rsp_tracked_ff)
      else $error("table touched by untracked message");

   a_total_drop: assert property (@(posedge clock) disable iff (reset)
      (conflict_total_ff < $past(conflict_total_ff)) |-> $past(accept && req_clear))
      else $error("conflict count fell without clear");

endmodule

[tb/bus_instance_conflict_detector_top_tb.sv]
// self-checking testbench for the bus instance conflict detector
module bus_instance_conflict_detector_top_tb
   import bicd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH    = 64;
   localparam int LIMIT_CYCLES   = 1000000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int RANDOM_TRACKED = 1150;

   localparam logic KIND_TRACK = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   localparam logic [GRP_W-1:0] INSTANCE_GROUPS [10] = '{
      PGN_SWITCH_STATUS, PGN_ENGINE_DYNAMIC, PGN_SWITCH_CONTROL, PGN_FLUID_LEVEL,
      PGN_BATTERY_STATUS, PGN_INVERTER_STATUS, PGN_BATTERY_CONFIG, PGN_TEMPERATURE,
      PGN_PRESSURE, PGN_TEMPERATURE_EXT
   };

   typedef struct packed {
      logic              kind;
      logic [GRP_W-1:0]  pgn;
      logic [SRC_W-1:0]  src;
      logic [LEN_W-1:0]  len;
      logic [7:0]        b0;
      logic [7:0]        b1;
   } message_type;

   typedef struct packed {
      logic              tracked;
      logic [INST_W-1:0] inst;
      logic              fresh;
      logic              full;
      logic [CNT_W-1:0]  count;
      logic              conflicted;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;  // pgn[16:0] source[24:17] data_len[32:25] byte0[40:33] byte1[48:41]
   logic [0:0]  req_tuser = '0;  // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // tracked[0] instance_seen[8:1] new_entry[9] table_full[10]
                                 // conflict_count[16:11] source_conflicted[17]

   bus_instance_conflict_detector_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   // predicted detector state
   logic [GRP_W-1:0]  stored_grp  [TABLE_DEPTH];
   logic [SRC_W-1:0]  stored_src  [TABLE_DEPTH];
   logic [INST_W-1:0] stored_inst [TABLE_DEPTH];
   int                stored_count = 0;
   logic [CNT_W-1:0]  conflict_tally = '0;
   logic [255:0]      source_flagged = '0;

   outcome_type expected_outcomes [$];
   int          errors = 0;
   int          tracked_sent = 0;
   int          cycle_count = 0;

   int       burst_left = 0;
   bit       steady = 1'b0;
   int       holdoff_req = 0;

   logic [SRC_W-1:0]  src_pool  [64];
   logic [GRP_W-1:0]  grp_pool  [10];
   logic [INST_W-1:0] inst_pool [4];
   int                src_pool_n, grp_pool_n, inst_pool_n;

   function automatic gkind_type group_slot(input logic [GRP_W-1:0] pgn);
      case (pgn)
         PGN_SWITCH_STATUS, PGN_ENGINE_DYNAMIC, PGN_FLUID_LEVEL,
         PGN_BATTERY_STATUS, PGN_INVERTER_STATUS, PGN_BATTERY_CONFIG:
            return GK_BYTE0;
         PGN_SWITCH_CONTROL, PGN_TEMPERATURE, PGN_PRESSURE, PGN_TEMPERATURE_EXT:
            return GK_BYTE1;
         default:
            return GK_NONE;
      endcase
   endfunction

   function automatic outcome_type predict_outcome(input message_type m);
      outcome_type       r;
      logic [INST_W-1:0] inst;
      logic              found;
      int                same;
      logic [SRC_W-1:0]  other;
      gkind_type         slot;
      r = '0;
      inst = NO_INSTANCE;
      found = 1'b0;
      same = 0;
      other = '0;
      if (m.kind == KIND_CLEAR) begin
         stored_count = 0;
         conflict_tally = '0;
         source_flagged = '0;
      end else begin
         slot = group_slot(m.pgn);
         if (slot == GK_BYTE0 && m.len >= LEN_BYTE0)
            inst = m.b0;
         else if (slot == GK_BYTE1 && m.len >= LEN_BYTE1)
            inst = m.b1;
         if (inst != NO_INSTANCE) begin
            r.tracked = 1'b1;
            for (int i = 0; i < stored_count; i++)
               if (stored_grp[i] == m.pgn && stored_src[i] == m.src)
                  found = 1'b1;
            if (!found && stored_count >= TABLE_DEPTH) begin
               r.full = 1'b1;
            end else if (!found) begin
               for (int i = 0; i < stored_count; i++) begin
                  if (stored_grp[i] == m.pgn && stored_inst[i] == inst) begin
                     same++;
                     other = stored_src[i];
                  end
               end
               stored_grp[stored_count]  = m.pgn;
               stored_src[stored_count]  = m.src;
               stored_inst[stored_count] = inst;
               stored_count++;
               r.fresh = 1'b1;
               if (same == 1) begin
                  if (conflict_tally != COUNT_MAX)
                     conflict_tally++;
                  source_flagged[other] = 1'b1;
               end
               if (same >= 1)
                  source_flagged[m.src] = 1'b1;
            end
         end
      end
      r.inst = inst;
      r.count = conflict_tally;
      r.conflicted = source_flagged[m.src];
      return r;
   endfunction

   function automatic message_type make_message(input logic kind, input logic [GRP_W-1:0] pgn,
                                                input logic [SRC_W-1:0] src,
                                                input logic [LEN_W-1:0] len,
                                                input logic [7:0] b0, input logic [7:0] b1);
      message_type m;
      m.kind = kind;
      m.pgn = pgn;
      m.src = src;
      m.len = len;
      m.b0 = b0;
      m.b1 = b1;
      return m;
   endfunction

   // instance placed in the byte its group uses, the other byte random
   function automatic message_type well_formed(input logic [GRP_W-1:0] pgn,
                                               input logic [SRC_W-1:0] src,
                                               input logic [INST_W-1:0] inst);
      message_type m;
      m = make_message(KIND_TRACK, pgn, src, 8'($urandom_range(2, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if (group_slot(pgn) == GK_BYTE0) begin
         m.b0 = inst;
         m.len = 8'($urandom_range(1, 255));
      end else begin
         m.b1 = inst;
      end
      return m;
   endfunction

   function automatic message_type pool_message();
      message_type m;
      int          pick;
      pick = $urandom_range(0, 99);
      m = well_formed(grp_pool[$urandom_range(0, grp_pool_n - 1)],
                      src_pool[$urandom_range(0, src_pool_n - 1)],
                      inst_pool[$urandom_range(0, inst_pool_n - 1)]);
      if (pick >= 95) begin
         m = well_formed(m.pgn, m.src, NO_INSTANCE);
      end else if (pick >= 88) begin
         m.len = (group_slot(m.pgn) == GK_BYTE0) ? 8'd0 : 8'($urandom_range(0, 1));
      end else if (pick >= 80) begin
         m = make_message(KIND_TRACK, 17'($urandom_range(0, 131071)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
      end
      return m;
   endfunction

   task automatic setup_pools();
      src_pool_n  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 64) : $urandom_range(2, 8);
      grp_pool_n  = $urandom_range(1, 10);
      inst_pool_n = $urandom_range(1, 4);
      foreach (src_pool[i])
         src_pool[i] = 8'($urandom_range(0, 255));
      foreach (grp_pool[i])
         grp_pool[i] = INSTANCE_GROUPS[$urandom_range(0, 9)];
      foreach (inst_pool[i])
         inst_pool[i] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom_range(0, 254));
   endtask

   task automatic send_request(input message_type m);
      outcome_type r;
      int          gap;
      req_tuser  <= m.kind;
      req_tdata  <= {7'd0, m.b1, m.b0, m.len, m.src, m.pgn};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      r = predict_outcome(m);
      expected_outcomes.push_back(r);
      if (r.tracked)
         tracked_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0 && !steady) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
         gap = $urandom_range(0, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(make_message(KIND_CLEAR, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_message(KIND_TRACK, 17'd0, 8'd0, 8'd255, 8'd0, 8'd0));
      send_request(make_message(KIND_TRACK, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      // each group with the unused byte at 255 to catch a wrong byte pick
      for (int i = 0; i < 10; i++) begin
         if (group_slot(INSTANCE_GROUPS[i]) == GK_BYTE0)
            send_request(make_message(KIND_TRACK, INSTANCE_GROUPS[i], 8'(10 + i), 8'd8,
                                      8'(i), 8'hFF));
         else
            send_request(make_message(KIND_TRACK, INSTANCE_GROUPS[i], 8'(10 + i), 8'd8,
                                      8'hFF, 8'(i)));
      end
      // payload too short
      send_request(make_message(KIND_TRACK, PGN_BATTERY_STATUS, 8'd40, 8'd0, 8'd3, 8'd3));
      send_request(make_message(KIND_TRACK, PGN_PRESSURE, 8'd40, 8'd1, 8'd3, 8'd3));
      // no instance
      send_request(make_message(KIND_TRACK, PGN_FLUID_LEVEL, 8'd41, 8'd8, 8'hFF, 8'd0));
      // pair already stored keeps its first instance
      send_request(make_message(KIND_TRACK, PGN_SWITCH_STATUS, 8'd10, 8'd1, 8'd77, 8'd0));
      // conflict, then a third source on the same instance
      send_request(make_message(KIND_TRACK, PGN_SWITCH_STATUS, 8'd200, 8'd1, 8'd0, 8'd0));
      send_request(make_message(KIND_TRACK, PGN_SWITCH_STATUS, 8'd255, 8'd2, 8'd0, 8'd9));
      send_request(make_message(KIND_TRACK, PGN_SWITCH_STATUS, 8'd10, 8'd4, 8'd0, 8'd0));
      send_request(make_message(KIND_TRACK, PGN_TEMPERATURE_EXT, 8'd0, 8'd255, 8'd0, 8'd254));
      send_request(make_message(KIND_CLEAR, 17'd0, 8'd10, 8'd0, 8'd0, 8'd0));
      send_request(make_message(KIND_TRACK, PGN_SWITCH_STATUS, 8'd10, 8'd1, 8'd0, 8'd0));
   endtask

   task automatic test_full_table();
      send_request(make_message(KIND_CLEAR, 17'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      // every two entries share group and instance, giving the largest conflict count
      for (int k = 0; k < TABLE_DEPTH / 2; k++) begin
         send_request(well_formed(INSTANCE_GROUPS[k % 10], 8'(2 * k), 8'(k)));
         send_request(well_formed(INSTANCE_GROUPS[k % 10], 8'(2 * k + 1), 8'(k)));
      end
      send_request(well_formed(PGN_SWITCH_STATUS, 8'd100, 8'd0));
      send_request(well_formed(PGN_PRESSURE, 8'd101, 8'd254));
      send_request(well_formed(INSTANCE_GROUPS[0], 8'd0, 8'd200));
      send_request(well_formed(PGN_TEMPERATURE, 8'd102, NO_INSTANCE));
   endtask

   task automatic test_backpressure();
      setup_pools();
      holdoff_req++;
      steady = 1'b1;
      repeat (12) send_request(pool_message());
      steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int session_len;
      while (tracked_sent < RANDOM_TRACKED) begin
         setup_pools();
         if ($urandom_range(0, 3) != 0)
            send_request(make_message(KIND_CLEAR, 17'($urandom_range(0, 131071)),
                                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
         session_len = $urandom_range(20, 120);
         repeat (session_len) send_request(pool_message());
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t ns: unexpected response, expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_outcomes.pop_front();
            check_field("tracked", want.tracked, rsp_tdata[0]);
            check_field("instance_seen", want.inst, rsp_tdata[8:1]);
            check_field("new_entry", want.fresh, rsp_tdata[9]);
            check_field("table_full", want.full, rsp_tdata[10]);
            check_field("conflict_count", want.count, rsp_tdata[16:11]);
            check_field("source_conflicted", want.conflicted, rsp_tdata[17]);
         end
      end
   end

   // response side stall pattern, with a long hold-off when the backpressure test asks for one
   int rx_mode = 0;
   int mode_left = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;

   always @(posedge clock) begin
      if (holdoff_seen != holdoff_req) begin
         holdoff_seen = holdoff_req;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (mode_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      wait_drained();
      test_full_table();
      wait_drained();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
